>>> rtl/core/wdp_pkg.sv
// Shared types and constants for the waveform delta packetizer.
// Used by every module under rtl/core; depends on nothing else.
package wdp_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_LIMIT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_LIMIT = 1'd1;

  localparam logic [7:0] BYTE_LIMIT_RST   = 8'd220;
  localparam logic [7:0] SAMPLE_LIMIT_RST = 8'd200;

  localparam logic [7:0]  ESCAPE_BYTE = 8'h80;
  localparam logic [15:0] DELTA_POS_MAX = 16'd127;
  localparam logic [15:0] DELTA_NEG_MIN = 16'hFF81;

  localparam logic [8:0] NEED_DELTA  = 9'd1;
  localparam logic [8:0] NEED_ESCAPE = 9'd3;
  localparam logic [7:0] BYTES_RAW   = 8'd2;

  typedef enum logic [1:0] {
    CMD_RAW    = 2'd0,
    CMD_DELTA  = 2'd1,
    CMD_ESCAPE = 2'd2
  } cmd_kind_t;

  typedef logic [1:0] byte_idx_t;
  localparam byte_idx_t BYTE_IDX_FIRST  = 2'd0;
  localparam byte_idx_t BYTE_IDX_SECOND = 2'd1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               record_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
    logic       record_end;
    logic       item_last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] sample;
    logic [7:0]  delta;
    logic        record_last;
  } cmd_t;

endpackage

>>> rtl/core/wdp_front.sv
// Front end: accepts samples, tracks packet state and classifies each sample
// into a raw, delta or escape command. Depends on wdp_pkg.
module wdp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wdp_pkg::in_item_t in_data,
  input  logic [7:0]        byte_limit,
  input  logic [7:0]        sample_limit,
  input  logic              q_full,
  output logic              q_push,
  output wdp_pkg::cmd_t     q_cmd
);

  logic [15:0] prev_r, prev_nxt;
  logic [7:0]  bytes_r, bytes_nxt;
  logic [7:0]  samples_r, samples_nxt;
  logic        open_r, open_nxt;

  logic [15:0] diff;
  logic        small_delta;
  logic [8:0]  need;
  logic        fresh;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    diff        = in_data.sample - prev_r;
    small_delta = (diff <= wdp_pkg::DELTA_POS_MAX) || (diff >= wdp_pkg::DELTA_NEG_MIN);
    need        = small_delta ? wdp_pkg::NEED_DELTA : wdp_pkg::NEED_ESCAPE;
    fresh       = !open_r || (samples_r >= sample_limit) ||
                  (({1'b0, bytes_r} + need) > {1'b0, byte_limit});

    q_push           = accept;
    q_cmd.sample     = in_data.sample;
    q_cmd.delta      = diff[7:0];
    q_cmd.record_last = in_data.record_last;
    if (fresh) begin
      q_cmd.kind = wdp_pkg::CMD_RAW;
    end else if (small_delta) begin
      q_cmd.kind = wdp_pkg::CMD_DELTA;
    end else begin
      q_cmd.kind = wdp_pkg::CMD_ESCAPE;
    end

    prev_nxt    = prev_r;
    bytes_nxt   = bytes_r;
    samples_nxt = samples_r;
    open_nxt    = open_r;
    if (accept) begin
      prev_nxt = in_data.sample;
      if (fresh) begin
        bytes_nxt   = wdp_pkg::BYTES_RAW;
        samples_nxt = 8'd1;
        open_nxt    = 1'b1;
      end else begin
        bytes_nxt   = bytes_r + need[7:0];
        samples_nxt = samples_r + 8'd1;
      end
      // close the packet after the record's final sample
      if (in_data.record_last) begin
        bytes_nxt   = '0;
        samples_nxt = '0;
        open_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      bytes_r   <= '0;
      samples_r <= '0;
      open_r    <= 1'b0;
    end else begin
      prev_r    <= prev_nxt;
      bytes_r   <= bytes_nxt;
      samples_r <= samples_nxt;
      open_r    <= open_nxt;
    end
  end

endmodule

>>> rtl/core/wdp_queue.sv
// Short command queue between the front and back ends.
// Depends on wdp_pkg for the command type.
module wdp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wdp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output wdp_pkg::cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wdp_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/core/wdp_back.sv
// Back end: expands queued commands into bytes, one per cycle while
// out_stall is low, into the output register. Depends on wdp_pkg.
module wdp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  wdp_pkg::cmd_t       head_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output wdp_pkg::out_item_t  out_data
);

  wdp_pkg::byte_idx_t idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  wdp_pkg::out_item_t out_data_r, out_data_nxt;

  logic [7:0] byte_sel;
  logic       start_sel;
  logic       last_sel;
  logic       load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    byte_sel  = head_cmd.delta;
    start_sel = 1'b0;
    last_sel  = 1'b1;
    case (head_cmd.kind)
      wdp_pkg::CMD_RAW: begin
        start_sel = (idx_r == wdp_pkg::BYTE_IDX_FIRST);
        last_sel  = (idx_r != wdp_pkg::BYTE_IDX_FIRST);
        byte_sel  = start_sel ? head_cmd.sample[15:8] : head_cmd.sample[7:0];
      end
      wdp_pkg::CMD_DELTA: begin
        byte_sel = head_cmd.delta;
        last_sel = 1'b1;
      end
      wdp_pkg::CMD_ESCAPE: begin
        last_sel = 1'b0;
        if (idx_r == wdp_pkg::BYTE_IDX_FIRST) begin
          byte_sel = wdp_pkg::ESCAPE_BYTE;
        end else if (idx_r == wdp_pkg::BYTE_IDX_SECOND) begin
          byte_sel = head_cmd.sample[15:8];
        end else begin
          byte_sel = head_cmd.sample[7:0];
          last_sel = 1'b1;
        end
      end
      default: begin
        byte_sel = head_cmd.delta;
        last_sel = 1'b1;
      end
    endcase

    load  = head_valid && (!out_valid_r || !out_stall);
    q_pop = load && last_sel;

    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_sel ? wdp_pkg::BYTE_IDX_FIRST : idx_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.data_byte    = byte_sel;
      out_data_nxt.packet_start = start_sel;
      out_data_nxt.record_end   = last_sel && head_cmd.record_last;
      out_data_nxt.item_last    = last_sel;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= wdp_pkg::BYTE_IDX_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/waveform_delta_packetizer.sv
// Waveform delta packetizer top level: configuration registers, front end,
// command queue and byte back end. Depends on wdp_pkg, wdp_front, wdp_queue, wdp_back.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_stall   | in_data  (sample, record_last)
//   out_       | output    | out_valid/out_stall | out_data (data_byte, flags)
//   cfg_       | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// One byte leaves per cycle while out_stall is low, a rate set by the single-byte
// output register; a delta sample is one byte, a raw sample two, an escaped three.
// Each sample is queued as a command, then its bytes are registered onto out_data.
// Reset clears the queue, packet state and output, and loads limits 220/200.
// in_stall rises when the command queue is full; out_stall holds the output byte.
module waveform_delta_packetizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wdp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wdp_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [wdp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wdp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [7:0] byte_limit_r, byte_limit_nxt;
  logic [7:0] sample_limit_r, sample_limit_nxt;

  logic          q_full;
  logic          q_push;
  wdp_pkg::cmd_t q_cmd;
  logic          q_pop;
  logic          head_valid;
  wdp_pkg::cmd_t head_cmd;

  always_comb begin
    byte_limit_nxt   = byte_limit_r;
    sample_limit_nxt = sample_limit_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        wdp_pkg::CFG_BYTE_LIMIT:   byte_limit_nxt   = cfg_wdata;
        wdp_pkg::CFG_SAMPLE_LIMIT: sample_limit_nxt = cfg_wdata;
        default: begin
          byte_limit_nxt = byte_limit_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r   <= wdp_pkg::BYTE_LIMIT_RST;
      sample_limit_r <= wdp_pkg::SAMPLE_LIMIT_RST;
    end else begin
      byte_limit_r   <= byte_limit_nxt;
      sample_limit_r <= sample_limit_nxt;
    end
  end

  wdp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .byte_limit   (byte_limit_r),
    .sample_limit (sample_limit_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  wdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  wdp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> bench/waveform_delta_packetizer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for waveform_delta_packetizer: drives samples and limits,
// predicts every packet byte and checks it. Depends on wdp_pkg and the RTL only.
module waveform_delta_packetizer_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BLOCK   = 56;

  class packet_byte_scoreboard;
    wdp_pkg::out_item_t expected_bytes[$];
    int unsigned        mismatches;
    logic [7:0]         byte_limit;
    logic [7:0]         sample_limit;
    logic [15:0]        last_sample;
    int unsigned        bytes_in_packet;
    int unsigned        samples_in_packet;
    bit                 packet_open;

    function new();
      mismatches        = 0;
      byte_limit        = wdp_pkg::BYTE_LIMIT_RST;
      sample_limit      = wdp_pkg::SAMPLE_LIMIT_RST;
      last_sample       = 16'h0000;
      bytes_in_packet   = 0;
      samples_in_packet = 0;
      packet_open       = 1'b0;
    endfunction

    // Encode one accepted sample into the bytes it must produce.
    function void note_sample(wdp_pkg::in_item_t item);
      logic [15:0]        value;
      logic [15:0]        diff;
      bit                 fits_delta;
      bit                 fresh;
      int unsigned        need;
      int                 count;
      wdp_pkg::out_item_t bytes_out[3];
      value      = item.sample;
      diff       = value - last_sample;
      fits_delta = $signed(diff) >= -127 && $signed(diff) <= 127;
      need       = fits_delta ? 1 : 3;
      fresh      = !packet_open || samples_in_packet >= sample_limit;
      if (!fresh && bytes_in_packet + need > byte_limit) begin
        fresh = 1'b1;
      end
      foreach (bytes_out[i]) begin
        bytes_out[i] = '0;
      end
      if (fresh) begin
        bytes_out[0].data_byte    = value[15:8];
        bytes_out[0].packet_start = 1'b1;
        bytes_out[1].data_byte    = value[7:0];
        count                     = 2;
        bytes_in_packet           = 2;
        samples_in_packet         = 1;
        packet_open               = 1'b1;
      end else if (fits_delta) begin
        bytes_out[0].data_byte = diff[7:0];
        count                  = 1;
        bytes_in_packet        += 1;
        samples_in_packet      += 1;
      end else begin
        bytes_out[0].data_byte = wdp_pkg::ESCAPE_BYTE;
        bytes_out[1].data_byte = value[15:8];
        bytes_out[2].data_byte = value[7:0];
        count                  = 3;
        bytes_in_packet        += 3;
        samples_in_packet      += 1;
      end
      bytes_out[count-1].item_last = 1'b1;
      if (item.record_last) begin
        // Close the packet: the next sample goes out raw.
        bytes_out[count-1].record_end = 1'b1;
        packet_open       = 1'b0;
        bytes_in_packet   = 0;
        samples_in_packet = 0;
      end
      last_sample = value;
      for (int i = 0; i < count; i++) begin
        expected_bytes.push_back(bytes_out[i]);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_byte(wdp_pkg::out_item_t got);
      wdp_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", got.data_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_byte !== want.data_byte) begin
        report_mismatch($sformatf("data_byte %02h, want %02h",
                                  got.data_byte, want.data_byte));
      end
      if (got.packet_start !== want.packet_start) begin
        report_mismatch($sformatf("packet_start %b, want %b (byte %02h)",
                                  got.packet_start, want.packet_start, want.data_byte));
      end
      if (got.record_end !== want.record_end) begin
        report_mismatch($sformatf("record_end %b, want %b (byte %02h)",
                                  got.record_end, want.record_end, want.data_byte));
      end
      if (got.item_last !== want.item_last) begin
        report_mismatch($sformatf("item_last %b, want %b (byte %02h)",
                                  got.item_last, want.item_last, want.data_byte));
      end
    endtask
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  wdp_pkg::in_item_t               in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  wdp_pkg::out_item_t              out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [wdp_pkg::CFG_INDEX_W-1:0] cfg_index = wdp_pkg::CFG_BYTE_LIMIT;
  logic [wdp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  packet_byte_scoreboard byte_sb;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  int unsigned           quiet_cycles  = 0;
  logic [15:0]           last_sent     = 16'h0000;

  waveform_delta_packetizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Byte sink with random stalls, plus a watchdog on the quiet stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      byte_sb.check_byte(out_data);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Call at a rising edge; returns at the edge where the item is taken.
  task automatic send_sample(input logic [15:0] value, input bit last);
    wdp_pkg::in_item_t item;
    item.sample      = value;
    item.record_last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    byte_sb.note_sample(item);
    last_sent = value;
  endtask

  // Hold off the sender until every predicted byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (byte_sb.expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_limits(input logic [7:0] byte_lim, input logic [7:0] sample_lim);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= wdp_pkg::CFG_BYTE_LIMIT;
    cfg_wdata <= byte_lim;
    @(posedge clk);
    cfg_index <= wdp_pkg::CFG_SAMPLE_LIMIT;
    cfg_wdata <= sample_lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    byte_sb.byte_limit   = byte_lim;
    byte_sb.sample_limit = sample_lim;
  endtask

  // Mostly a wandering waveform, with jumps, boundary deltas and rail values.
  task automatic run_random(input int count);
    logic [15:0] value;
    logic [15:0] step;
    int          pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        step  = 16'($urandom_range(254));
        value = last_sent + step - 16'd127;
      end else if (pick < 65) begin
        case ($urandom_range(3))
          0:       step = 16'd127;
          1:       step = 16'hFF81;
          2:       step = 16'hFF80;
          default: step = 16'd128;
        endcase
        value = last_sent + step;
      end else if (pick < 85) begin
        value = 16'($urandom_range(16'hFFFF));
      end else if (pick < 93) begin
        case ($urandom_range(3))
          0:       value = 16'h8000;
          1:       value = 16'h7FFF;
          2:       value = 16'h0000;
          default: value = 16'hFFFF;
        endcase
      end else begin
        value = last_sent;
      end
      send_sample(value, $urandom_range(19) == 0);
    end
  endtask

  initial begin
    byte_sb       = new();
    send_idle_pct = 6;
    recv_idle_pct = 51;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limits: delta edges, escapes, wraparound and record ends.
    send_sample(16'h0000, 1'b0);
    send_sample(16'h007F, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFF80, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h1234, 1'b1);

    // Byte limit below three: every sample still goes out raw.
    set_limits(8'd2, 8'd255);
    send_sample(16'h0010, 1'b0);
    send_sample(16'h0011, 1'b0);

    // Sample limit zero behaves as one.
    set_limits(8'd255, 8'd0);
    send_sample(16'h0020, 1'b0);
    send_sample(16'h0021, 1'b0);

    // Fill to the sample limit, then overflow the byte limit with a sample needing an escape.
    set_limits(8'd4, 8'd3);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h0101, 1'b0);
    send_sample(16'h0102, 1'b0);
    send_sample(16'h0103, 1'b0);
    send_sample(16'h4000, 1'b0);

    set_limits(8'd255, 8'd255);
    run_random(RANDOM_BLOCK);
    set_limits(8'($urandom_range(3, 40)), 8'($urandom_range(1, 12)));
    run_random(RANDOM_BLOCK);

    send_idle_pct = 51;
    recv_idle_pct = 6;
    set_limits(8'd3, 8'd255);
    run_random(RANDOM_BLOCK);
    set_limits(8'($urandom_range(3, 40)), 8'($urandom_range(1, 12)));
    run_random(RANDOM_BLOCK);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_random(RANDOM_BLOCK);
    set_limits(wdp_pkg::BYTE_LIMIT_RST, wdp_pkg::SAMPLE_LIMIT_RST);
    run_random(RANDOM_BLOCK);

    wait_drained();
    repeat (8) @(posedge clk);
    if (byte_sb.mismatches == 0 && byte_sb.expected_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
